FILE: rtl/core/mdl_pkg.sv
`default_nettype none

package mdl_pkg;

	// Store geometry and sample format
	localparam int DEPTH        = 32768;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ADDR_W       = $clog2(DEPTH);

	// Register field widths and reset values
	localparam int BASE_W        = 15;
	localparam int GAIN_W        = 16;
	localparam int CV_W          = 16;
	localparam logic [BASE_W-1:0] BASE_DELAY_RST = BASE_W'(24576);
	localparam logic [GAIN_W-1:0] MIX_GAIN_RST   = GAIN_W'(13107);

	// APB register map: register i at byte address 4*i
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_BASE_DELAY = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_MIX_GAIN   = REG_IDX_W'(1);

	// Delay computation: delay_cv * DEPTH, floor-shifted by 16
	localparam int DCV_PROD_W = CV_W + ADDR_W + 1;
	localparam int DCV_SHF_W  = DCV_PROD_W - 16;
	localparam int DLY_SUM_W  = ((DCV_SHF_W > BASE_W + 1) ? DCV_SHF_W : BASE_W + 1) + 1;
	localparam logic signed [DLY_SUM_W-1:0] DLY_MAX = DLY_SUM_W'(DEPTH - 1);

	// Dry path: mix_gain * sample, floor-shifted by 15
	localparam int DRY_PROD_W = SAMPLE_WIDTH + GAIN_W + 1;
	localparam int DRY_W      = DRY_PROD_W - 15;
	localparam int ACC_W      = DRY_W + 1;
	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SMIN = -(ACC_W'(1 << (SAMPLE_WIDTH - 1)));

	// Read head offset: read_cv * delay, truncated by 15
	localparam int OFS_PROD_W = CV_W + ADDR_W + 1;
	localparam int OFS_W      = OFS_PROD_W - 15;
	localparam int HEAD_W     = ADDR_W + 3;

	typedef struct packed {
		logic [BASE_W-1:0] base_delay;
		logic [GAIN_W-1:0] mix_gain;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_step;
		logic capture;
		logic read;
		logic mult;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_done;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/core/mdl_stream_if.sv
`default_nettype none

// Input item channel
interface mdl_item_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [mdl_pkg::SAMPLE_WIDTH-1:0] sample_in;
	logic signed [mdl_pkg::CV_W-1:0]         delay_cv;
	logic signed [mdl_pkg::CV_W-1:0]         read_cv;

	modport source (output valid, sample_in, delay_cv, read_cv, input ready);
	modport sink   (input valid, sample_in, delay_cv, read_cv, output ready);
endinterface

// Result channel
interface mdl_result_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [mdl_pkg::SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mdl_regs.sv
`default_nettype none

module mdl_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mdl_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [mdl_pkg::PDATA_W-1:0]  pwdata,
	output logic      [mdl_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output mdl_pkg::cfg_t                     cfg
);

	logic [mdl_pkg::REG_IDX_W-1:0] idx;
	logic                          wr_en;
	mdl_pkg::cfg_t                 cfg_q;

	assign idx    = paddr[mdl_pkg::PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_delay <= mdl_pkg::BASE_DELAY_RST;
			cfg_q.mix_gain   <= mdl_pkg::MIX_GAIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				mdl_pkg::REG_BASE_DELAY: cfg_q.base_delay <= pwdata[mdl_pkg::BASE_W-1:0];
				mdl_pkg::REG_MIX_GAIN:   cfg_q.mix_gain   <= pwdata[mdl_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Readback
	always_comb begin
		unique case (idx)
			mdl_pkg::REG_BASE_DELAY:
				prdata = mdl_pkg::PDATA_W'(cfg_q.base_delay);
			mdl_pkg::REG_MIX_GAIN:
				prdata = mdl_pkg::PDATA_W'(cfg_q.mix_gain);
			default:
				prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/mdl_ctrl.sv
`default_nettype none

module mdl_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire mdl_pkg::status_t status,
	output mdl_pkg::cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MULT,
		ST_UPDATE
	} state_t;

	state_t state_q;

	assign item_ready = (state_q == ST_IDLE);

	// Commands decoded from state
	always_comb begin
		cmd          = '0;
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.capture  = (state_q == ST_IDLE) & item_valid;
		cmd.read     = (state_q == ST_READ);
		cmd.mult     = (state_q == ST_MULT);
		cmd.commit   = (state_q == ST_UPDATE) & ~status.out_busy;
	end

	// Sequencer: clear pass after reset, then four steps per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clr_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (item_valid) state_q <= ST_READ;
				end
				ST_READ:   state_q <= ST_MULT;
				ST_MULT:   state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (!status.out_busy) state_q <= ST_IDLE;
				end
				default:   state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/mdl_dp.sv
`default_nettype none

module mdl_dp (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire mdl_pkg::cfg_t                           cfg,
	input  wire mdl_pkg::cmd_t                           cmd,
	output mdl_pkg::status_t                             status,
	input  wire logic signed [mdl_pkg::SAMPLE_WIDTH-1:0] sample_in,
	input  wire logic signed [mdl_pkg::CV_W-1:0]         delay_cv,
	input  wire logic signed [mdl_pkg::CV_W-1:0]         read_cv,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic signed [mdl_pkg::SAMPLE_WIDTH-1:0]      sample_out
);

	localparam int SW = mdl_pkg::SAMPLE_WIDTH;
	localparam int AW = mdl_pkg::ADDR_W;

	// Sample store
	logic [SW-1:0] mem [mdl_pkg::DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [SW-1:0] mem_wdata;
	logic [SW-1:0] rdata_q;

	// Control state
	logic [AW-1:0] clr_q;
	logic [AW-1:0] read_pos_q;
	logic [AW-1:0] write_pos_q;
	logic          out_valid_q;

	// Payload registers
	logic signed [SW-1:0]                 x_q;
	logic signed [mdl_pkg::CV_W-1:0]      dcv_q;
	logic signed [mdl_pkg::CV_W-1:0]      rcv_q;
	logic [AW-1:0]                        delay_q;
	logic signed [mdl_pkg::DRY_W-1:0]     dry_q;
	logic signed [mdl_pkg::OFS_PROD_W-1:0] prod_q;
	logic signed [SW-1:0]                 sat_q;
	logic [AW:0]                          wp1_q;
	logic signed [SW-1:0]                 out_q;

	// Combinational terms
	logic signed [mdl_pkg::DCV_PROD_W-1:0] dcv_prod;
	logic signed [mdl_pkg::DLY_SUM_W-1:0]  dly_sum;
	logic [AW-1:0]                         delay_c;
	logic signed [mdl_pkg::DRY_PROD_W-1:0] dry_prod;
	logic signed [mdl_pkg::ACC_W-1:0]      acc;
	logic signed [SW-1:0]                  sat_c;
	logic signed [mdl_pkg::OFS_W-1:0]      ofs;
	logic signed [mdl_pkg::HEAD_W-1:0]     rp_sum;
	logic signed [mdl_pkg::HEAD_W-1:0]     rp_wrap;
	logic signed [mdl_pkg::HEAD_W-1:0]     dly_ext;
	logic [AW:0]                           dly_u;
	logic [AW-1:0]                         rp_next;
	logic [AW-1:0]                         wp_next;

	assign status.clr_done = (clr_q == AW'(mdl_pkg::DEPTH - 1));
	assign status.out_busy = out_valid_q & ~out_ready;
	assign out_valid       = out_valid_q;
	assign sample_out      = out_q;

	// Store write port: zero fill during the clear pass, else the new sample
	always_comb begin
		mem_we    = cmd.clr_step | cmd.read;
		mem_waddr = cmd.clr_step ? clr_q : write_pos_q;
		mem_wdata = cmd.clr_step ? '0 : x_q;
	end

	// Read-before-write: the old sample is seen when both heads coincide
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.read) rdata_q <= mem[read_pos_q];
	end

	// Delay: base + floor(delay_cv * DEPTH / 65536), clamped to the store
	always_comb begin
		dcv_prod = mdl_pkg::DCV_PROD_W'(dcv_q) *
		           $signed(mdl_pkg::DCV_PROD_W'(mdl_pkg::DEPTH));
		dly_sum  = mdl_pkg::DLY_SUM_W'($signed(dcv_prod[mdl_pkg::DCV_PROD_W-1:16])) +
		           $signed(mdl_pkg::DLY_SUM_W'({1'b0, cfg.base_delay}));
		if (dly_sum < 0)
			delay_c = '0;
		else if (dly_sum > mdl_pkg::DLY_MAX)
			delay_c = AW'(mdl_pkg::DEPTH - 1);
		else
			delay_c = dly_sum[AW-1:0];
	end

	// Dry term and saturating sum
	always_comb begin
		dry_prod = $signed({1'b0, cfg.mix_gain}) * x_q;
		acc      = mdl_pkg::ACC_W'($signed(rdata_q)) + mdl_pkg::ACC_W'(dry_q);
		if (acc > mdl_pkg::SMAX)
			sat_c = mdl_pkg::SMAX[SW-1:0];
		else if (acc < mdl_pkg::SMIN)
			sat_c = mdl_pkg::SMIN[SW-1:0];
		else
			sat_c = acc[SW-1:0];
	end

	// Head update: offset truncated toward zero, single wrap on the delay
	always_comb begin
		ofs = prod_q[mdl_pkg::OFS_PROD_W-1:15];
		if (prod_q[mdl_pkg::OFS_PROD_W-1] && (prod_q[14:0] != '0))
			ofs = ofs + mdl_pkg::OFS_W'(1);
		dly_u   = {1'b0, delay_q};
		dly_ext = $signed(mdl_pkg::HEAD_W'(delay_q));
		rp_sum  = $signed(mdl_pkg::HEAD_W'(wp1_q)) + mdl_pkg::HEAD_W'(ofs);
		rp_wrap = (rp_sum < 0) ? rp_sum + dly_ext : rp_sum;
		if (delay_q != '0) begin
			rp_next = (rp_wrap >= dly_ext) ? AW'(rp_wrap - dly_ext) : AW'(rp_wrap);
			wp_next = (wp1_q >= dly_u) ? AW'(wp1_q - dly_u) : AW'(wp1_q);
		end else begin
			rp_next = '0;
			wp_next = '0;
		end
	end

	// Payload pipeline
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q   <= sample_in;
			dcv_q <= delay_cv;
			rcv_q <= read_cv;
		end
		if (cmd.read) begin
			delay_q <= delay_c;
			dry_q   <= dry_prod[mdl_pkg::DRY_PROD_W-1:15];
		end
		if (cmd.mult) begin
			prod_q <= mdl_pkg::OFS_PROD_W'(rcv_q) * $signed({1'b0, delay_q});
			sat_q  <= sat_c;
			wp1_q  <= {1'b0, write_pos_q} + (AW+1)'(1);
		end
		if (cmd.commit) out_q <= sat_q;
	end

	// Heads, clear counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			read_pos_q  <= '0;
			write_pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.commit) begin
				read_pos_q  <= rp_next;
				write_pos_q <= wp_next;
			end
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/modulated_audio_delay_line.sv
`default_nettype none

// Modulated audio delay line. Each transfer on the item channel carries one
// signed sample plus two Q1.15 controls: delay_cv swings the delay by up to
// half the store around base_delay, and read_cv places the read head as a
// fraction of that delay from the write head. Each item gives one result,
// the stored sample under the read head plus the input scaled by mix_gain,
// saturated. The item is captured in the cycle of its transfer; its result
// is then worked out in order: store read together with the delay and
// dry-gain multiply, the read-offset multiply with the saturating add, then
// the head update, which loads the output register. The sequencer
// serializes items, so a new item is taken only once the last result is
// loaded; a result waiting in the output register does not block the next
// item until that item reaches its last step, the head update. After reset
// the store is zero filled one entry per cycle, all DEPTH entries, before
// the first item is taken; register writes over APB are accepted throughout.

module modulated_audio_delay_line (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	mdl_item_if.sink                         item,
	mdl_result_if.source                     result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mdl_pkg::PADDR_W-1:0] paddr,
	input  wire logic [mdl_pkg::PDATA_W-1:0] pwdata,
	output logic      [mdl_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);

	mdl_pkg::cfg_t    cfg;
	mdl_pkg::cmd_t    cmd;
	mdl_pkg::status_t status;
	logic             item_ready;

	assign item.ready = item_ready;

	// Configuration registers
	mdl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	mdl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// Store, arithmetic and heads
	mdl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.status     (status),
		.sample_in  (item.sample_in),
		.delay_cv   (item.delay_cv),
		.read_cv    (item.read_cv),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.sample_out (result.sample_out)
	);

endmodule

`default_nettype wire
